// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- src/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, op codes and control/status types of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int HEAP_BYTES = 4096;
  localparam int UNIT_BYTES = 8;
  localparam int UNITS      = HEAP_BYTES / UNIT_BYTES;
  localparam int PTR_W      = 10;
  localparam int NU_W       = 14;
  localparam int CNT_W      = 12;
  localparam logic [PTR_W-1:0] SENT = PTR_W'(UNITS);
  localparam logic [CNT_W-1:0] WALK_CAP = CNT_W'(4 * (UNITS + 2));
  localparam logic [CNT_W-1:0] REL_CAP  = CNT_W'(UNITS + 2);

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_A_START  = 5'd2;
  localparam logic [OP_W-1:0] OP_A_RESUME = 5'd3;
  localparam logic [OP_W-1:0] OP_A_FETCH  = 5'd4;
  localparam logic [OP_W-1:0] OP_A_STEP   = 5'd5;
  localparam logic [OP_W-1:0] OP_A_EXACT  = 5'd6;
  localparam logic [OP_W-1:0] OP_A_CUT1   = 5'd7;
  localparam logic [OP_W-1:0] OP_A_CUT2   = 5'd8;
  localparam logic [OP_W-1:0] OP_A_GROW   = 5'd9;
  localparam logic [OP_W-1:0] OP_A_FAIL   = 5'd10;
  localparam logic [OP_W-1:0] OP_R_START  = 5'd11;
  localparam logic [OP_W-1:0] OP_R_STEP   = 5'd12;
  localparam logic [OP_W-1:0] OP_R_FOUND  = 5'd13;
  localparam logic [OP_W-1:0] OP_R_F2     = 5'd14;
  localparam logic [OP_W-1:0] OP_R_F3     = 5'd15;
  localparam logic [OP_W-1:0] OP_R_F4     = 5'd16;
  localparam logic [OP_W-1:0] OP_R_F5     = 5'd17;
  localparam logic [OP_W-1:0] OP_R_F6     = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ffa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic free_ok;
    logic fit;
    logic exact;
    logic at_rover;
    logic can_grow;
    logic acap;
    logic found;
    logic rcap;
  } ffa_stat_t;
endpackage

// ----- src/ffa_dp.sv -----
// ----------------------------------------------------------------------------
// ffa_dp
// Header memories, list registers and pointer arithmetic of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffa_dp import ffa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd,
  input  logic [15:0] alloc_bytes,
  input  logic [11:0] free_addr,
  input  ffa_cmd_t    ctl,
  output ffa_stat_t   stat,
  output logic [11:0] addr,
  output logic        ok
);
  logic [PTR_W-1:0] nxt_mem [UNITS];
  logic [PTR_W-1:0] sz_mem  [UNITS];
  logic [PTR_W-1:0] nxt_q, sz_q, nra_q, sra_q, nra, sra;
  logic [PTR_W-1:0] rover, sentinel_next, p, prevp, bp, nx, sbp, nnx, sp, nbp;
  logic [8:0]       break_unit;
  logic             list_started;
  logic [NU_W-1:0]  nunits;
  logic [CNT_W-1:0] n;
  logic [PTR_W-1:0] nv, sv, pp1;
  logic             wn_en, ws_en;
  logic [PTR_W-1:0] wn_a, wn_d, ws_a, ws_d;
  logic [16:0]      bsum;
  logic             merge_u, merge_l;

  assign nv  = nra_q[PTR_W-1] ? ((nra_q == SENT) ? sentinel_next : SENT) : nxt_q;
  assign sv  = sra_q[PTR_W-1] ? '0 : sz_q;
  assign pp1 = p + 10'd1;
  assign bsum = {1'b0, alloc_bytes} + 17'd7;
  assign merge_u = (nx != SENT) && (({1'b0, bp} + {1'b0, sbp}) == {1'b0, nx});
  assign merge_l = (p != SENT) && (({1'b0, p} + {1'b0, sv}) == {1'b0, bp});

  always_comb begin
    stat.is_alloc = !cmd;
    stat.free_ok  = list_started && (free_addr[11:3] != 9'd0);
    stat.fit      = {4'd0, sv} >= nunits;
    stat.exact    = {4'd0, sv} == nunits;
    stat.at_rover = p == rover;
    stat.can_grow = (nunits < NU_W'(UNITS)) &&
                    (({5'd0, break_unit} + nunits) < NU_W'(UNITS));
    stat.acap     = n >= WALK_CAP;
    stat.found    = ((bp > p) && (bp < nv)) || ((p >= nv) && ((bp > p) || (bp < nv)));
    stat.rcap     = n >= REL_CAP;
  end

  always_comb begin
    nra   = rover;
    sra   = rover;
    wn_en = 1'b0;
    wn_a  = p;
    wn_d  = bp;
    ws_en = 1'b0;
    ws_a  = p;
    ws_d  = nunits[PTR_W-1:0];
    unique case (ctl.op)
      OP_A_START, OP_A_RESUME, OP_R_START: begin
        nra = rover;
      end
      OP_A_FETCH, OP_A_STEP: begin
        nra = nv;
        sra = nv;
      end
      OP_A_EXACT: begin
        wn_en = 1'b1;
        wn_a  = prevp;
        wn_d  = nv;
      end
      OP_A_CUT1: begin
        ws_en = 1'b1;
        ws_d  = sv - nunits[PTR_W-1:0];
      end
      OP_A_CUT2: begin
        ws_en = 1'b1;
      end
      OP_A_GROW: begin
        ws_en = 1'b1;
        ws_a  = {1'b0, break_unit};
      end
      OP_R_STEP: begin
        nra = nv;
      end
      OP_R_FOUND: begin
        sra = bp;
        nra = nv;
      end
      OP_R_F2: begin
        sra = nx;
      end
      OP_R_F3: begin
        wn_en = 1'b1;
        wn_a  = bp;
        ws_a  = bp;
        ws_d  = sbp + sv;
        ws_en = merge_u;
        wn_d  = merge_u ? nnx : nx;
      end
      OP_R_F4: begin
        sra = p;
        nra = bp;
      end
      OP_R_F5: begin
        sra = bp;
      end
      OP_R_F6: begin
        wn_en = 1'b1;
        ws_d  = sp + sv;
        ws_en = (p != SENT) && (({1'b0, p} + {1'b0, sp}) == {1'b0, bp});
        wn_d  = ws_en ? nbp : bp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wn_en && !wn_a[PTR_W-1]) begin
      nxt_mem[wn_a[PTR_W-2:0]] <= wn_d;
    end
    if (ws_en && !ws_a[PTR_W-1]) begin
      sz_mem[ws_a[PTR_W-2:0]] <= ws_d;
    end
    nxt_q <= nxt_mem[nra[PTR_W-2:0]];
    sz_q  <= sz_mem[sra[PTR_W-2:0]];
    nra_q <= nra;
    sra_q <= sra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rover         <= SENT;
      sentinel_next <= SENT;
      list_started  <= 1'b0;
      break_unit    <= '0;
    end else begin
      if (wn_en && (wn_a == SENT)) begin
        sentinel_next <= wn_d;
      end
      if (ctl.op == OP_LOAD && !cmd) begin
        list_started <= 1'b1;
      end
      if (ctl.op == OP_A_EXACT || ctl.op == OP_A_CUT1) begin
        rover <= prevp;
      end
      if (ctl.op == OP_R_F6) begin
        rover <= p;
      end
      if (ctl.op == OP_A_GROW) begin
        break_unit <= break_unit + nunits[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        nunits <= bsum[16:3] + 14'd1;
        bp     <= {1'b0, free_addr[11:3] - 9'd1};
        addr   <= '0;
        ok     <= 1'b1;
      end
      OP_A_START: begin
        prevp <= rover;
        n     <= '0;
      end
      OP_A_RESUME: begin
        prevp <= rover;
        n     <= 12'd1;
      end
      OP_A_FETCH: begin
        p <= nv;
      end
      OP_A_STEP: begin
        p     <= nv;
        prevp <= p;
        n     <= n + 12'd1;
      end
      OP_A_EXACT: begin
        addr <= {pp1[8:0], 3'b000};
      end
      OP_A_CUT1: begin
        p <= p + sv - nunits[PTR_W-1:0];
      end
      OP_A_CUT2: begin
        addr <= {pp1[8:0], 3'b000};
      end
      OP_A_GROW: begin
        bp <= {1'b0, break_unit};
      end
      OP_A_FAIL: begin
        ok <= 1'b0;
      end
      OP_R_START: begin
        p <= rover;
        n <= '0;
      end
      OP_R_STEP: begin
        p <= nv;
        n <= n + 12'd1;
      end
      OP_R_FOUND: begin
        nx <= nv;
      end
      OP_R_F2: begin
        sbp <= sv;
        nnx <= nv;
      end
      OP_R_F5: begin
        sp  <= sv;
        nbp <= nv;
      end
      default: begin
      end
    endcase
  end
endmodule

// ----- src/ffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate walks, heap growth and address-ordered release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ffa_stat_t stat,
  output ffa_cmd_t  ctl,
  output logic      busy,
  output logic      valid
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASTART = 4'd1;
  localparam logic [3:0] S_ARES   = 4'd2;
  localparam logic [3:0] S_AFETCH = 4'd3;
  localparam logic [3:0] S_ACHK   = 4'd4;
  localparam logic [3:0] S_ACUT2  = 4'd5;
  localparam logic [3:0] S_RSTART = 4'd6;
  localparam logic [3:0] S_RCHK   = 4'd7;
  localparam logic [3:0] S_RF2    = 4'd8;
  localparam logic [3:0] S_RF3    = 4'd9;
  localparam logic [3:0] S_RF4    = 4'd10;
  localparam logic [3:0] S_RF5    = 4'd11;
  localparam logic [3:0] S_RF6    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;
  logic       ret, ret_next;

  assign busy  = state != S_IDLE;
  assign valid = state == S_DONE;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctl.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op   = OP_LOAD;
          ret_next = 1'b0;
          if (stat.is_alloc) state_next = S_ASTART;
          else if (stat.free_ok) state_next = S_RSTART;
          else state_next = S_DONE;
        end
      end
      S_ASTART: begin
        ctl.op     = OP_A_START;
        state_next = S_AFETCH;
      end
      S_ARES: begin
        ctl.op     = OP_A_RESUME;
        state_next = S_AFETCH;
      end
      S_AFETCH: begin
        ctl.op     = OP_A_FETCH;
        state_next = S_ACHK;
      end
      S_ACHK: begin
        if (stat.fit && stat.exact) begin
          ctl.op     = OP_A_EXACT;
          state_next = S_DONE;
        end else if (stat.fit) begin
          ctl.op     = OP_A_CUT1;
          state_next = S_ACUT2;
        end else if (stat.at_rover && stat.can_grow) begin
          ctl.op     = OP_A_GROW;
          ret_next   = 1'b1;
          state_next = S_RSTART;
        end else if (stat.at_rover || stat.acap) begin
          ctl.op     = OP_A_FAIL;
          state_next = S_DONE;
        end else begin
          ctl.op     = OP_A_STEP;
        end
      end
      S_ACUT2: begin
        ctl.op     = OP_A_CUT2;
        state_next = S_DONE;
      end
      S_RSTART: begin
        ctl.op     = OP_R_START;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (stat.found) begin
          ctl.op     = OP_R_FOUND;
          state_next = S_RF2;
        end else if (stat.rcap) begin
          state_next = ret ? S_ARES : S_DONE;
        end else begin
          ctl.op = OP_R_STEP;
        end
      end
      S_RF2: begin
        ctl.op     = OP_R_F2;
        state_next = S_RF3;
      end
      S_RF3: begin
        ctl.op     = OP_R_F3;
        state_next = S_RF4;
      end
      S_RF4: begin
        ctl.op     = OP_R_F4;
        state_next = S_RF5;
      end
      S_RF5: begin
        ctl.op     = OP_R_F5;
        state_next = S_RF6;
      end
      S_RF6: begin
        ctl.op     = OP_R_F6;
        state_next = ret ? S_ARES : S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end
endmodule

// ----- src/first_fit_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit heap allocator with an address-ordered circular free list.
// ----------------------------------------------------------------------------
// channel   signals                           beat taken when
// request   start cmd alloc_bytes free_addr   start && !busy
// result    valid addr ok                     valid (one cycle, no stall)
//
// An allocate loads the request and checks one list block per step, plus a
// cut step when a block is split; a heap growth adds a release and a resume.
// A release walks from the rover, then links and merges the freed block.
// The walk is bound by the single read port of each header memory.
// Reset is synchronous; the header memories are not cleared.
// The result shows for one cycle in the cycle before busy falls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_free_list_allocator_unit import ffa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [15:0] alloc_bytes,
  input  logic [11:0] free_addr,
  output logic        valid,
  output logic [11:0] addr,
  output logic        ok
);
  ffa_cmd_t  ctl;
  ffa_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .valid (valid)
  );

  ffa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .alloc_bytes (alloc_bytes),
    .free_addr   (free_addr),
    .ctl         (ctl),
    .stat        (stat),
    .addr        (addr),
    .ok          (ok)
  );

  `ASSERT_IMP(a_fail_addr, clk, rst, valid && !ok, addr == 12'd0)
  `ASSERT_IMP(a_valid_busy, clk, rst, valid, busy)
  `ASSERT_NXT(a_valid_pulse, clk, rst, valid, !valid && !busy)
  `ASSERT_NXT(a_take_busy, clk, rst, start && !busy, busy)
endmodule
